/* rtl/pidsc_pkg.sv */
// Shared widths and register indexes for the clamped PID speed controller.
// No dependencies; every rtl file refers to it by scoped names.
package pidsc_pkg;

    localparam int SETPOINT_W  = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 23;
    localparam int SUM_W       = 24;
    localparam int DRIVE_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KP             = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KI             = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KD             = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

endpackage

/* rtl/pid_speed_controller_clamped.sv */
// Positional PID speed controller with a clamped integrator.
// A word accepted from s_tdata reaches m_tvalid through the input register,
// then the error/integrator, multiply and sum/saturate registers.
// Throughput: one word per cycle while m_tready is high; full stages hold.
// Reset (rst_n low, asynchronous) clears all valids, the configuration
// registers, the integrator and the stored previous error.
module pid_speed_controller_clamped #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // speed_sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pidsc_pkg::DRIVE_W-1:0]         m_tdata,   // drive_value
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pidsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int EW = ((SAMPLE_WIDTH > pidsc_pkg::SETPOINT_W) ? SAMPLE_WIDTH
                         : pidsc_pkg::SETPOINT_W) + 1;

    logic signed [pidsc_pkg::SETPOINT_W-1:0] setpoint_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     kp_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     ki_reg;
    logic signed [pidsc_pkg::GAIN_W-1:0]     kd_reg;
    logic        [pidsc_pkg::LIMIT_W-1:0]    limit_reg;

    logic signed [SAMPLE_WIDTH-1:0]          sample_reg;
    logic                                    in_valid_reg;

    logic                                    err_ready;
    logic                                    err_valid;
    logic signed [EW-1:0]                    err;
    logic signed [pidsc_pkg::SUM_W-1:0]      error_sum;
    logic signed [EW:0]                      diff;

    logic                                    prod_ready;
    logic                                    prod_valid;
    logic signed [pidsc_pkg::GAIN_W+EW-1:0]              p_term;
    logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::SUM_W-1:0] i_term;
    logic signed [pidsc_pkg::GAIN_W+EW:0]                d_term;

    logic                                    out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            limit_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pidsc_pkg::REG_SETPOINT:
                begin
                    setpoint_reg <= cfg_data[pidsc_pkg::SETPOINT_W-1:0];
                end
                pidsc_pkg::REG_KP:
                begin
                    kp_reg <= cfg_data[pidsc_pkg::GAIN_W-1:0];
                end
                pidsc_pkg::REG_KI:
                begin
                    ki_reg <= cfg_data[pidsc_pkg::GAIN_W-1:0];
                end
                pidsc_pkg::REG_KD:
                begin
                    kd_reg <= cfg_data[pidsc_pkg::GAIN_W-1:0];
                end
                pidsc_pkg::REG_INTEGRAL_LIMIT:
                begin
                    limit_reg <= cfg_data[pidsc_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // input register
    assign s_tready = !in_valid_reg || err_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    pidsc_error_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_error (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid_reg),
        .in_ready       (err_ready),
        .sample         (sample_reg),
        .setpoint       (setpoint_reg),
        .integral_limit (limit_reg),
        .out_valid      (err_valid),
        .out_ready      (prod_ready),
        .err            (err),
        .error_sum      (error_sum),
        .diff           (diff)
    );

    pidsc_product_stage #(
        .EW (EW)
    ) u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (prod_ready),
        .err       (err),
        .error_sum (error_sum),
        .diff      (diff),
        .kp        (kp_reg),
        .ki        (ki_reg),
        .kd        (kd_reg),
        .out_valid (prod_valid),
        .out_ready (out_ready),
        .p_term    (p_term),
        .i_term    (i_term),
        .d_term    (d_term)
    );

    pidsc_output_stage #(
        .EW             (EW),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (prod_valid),
        .in_ready    (out_ready),
        .p_term      (p_term),
        .i_term      (i_term),
        .d_term      (d_term),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .drive_value (m_tdata)
    );

endmodule

/* rtl/pidsc_error_stage.sv */
// Error stage: forms setpoint - speed, updates the clamped integrator and
// the derivative difference. Holds the controller state. Uses pidsc_pkg.
module pidsc_error_stage #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample,
    input  logic signed [pidsc_pkg::SETPOINT_W-1:0] setpoint,
    input  logic        [pidsc_pkg::LIMIT_W-1:0]   integral_limit,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [((SAMPLE_WIDTH > pidsc_pkg::SETPOINT_W) ? SAMPLE_WIDTH
                          : pidsc_pkg::SETPOINT_W):0] err,
    output logic signed [pidsc_pkg::SUM_W-1:0]     error_sum,
    output logic signed [((SAMPLE_WIDTH > pidsc_pkg::SETPOINT_W) ? SAMPLE_WIDTH
                          : pidsc_pkg::SETPOINT_W)+1:0] diff
);

    localparam int EW = ((SAMPLE_WIDTH > pidsc_pkg::SETPOINT_W) ? SAMPLE_WIDTH
                         : pidsc_pkg::SETPOINT_W) + 1;
    localparam int DW = EW + 1;
    localparam int AW = ((EW > pidsc_pkg::SUM_W) ? EW : pidsc_pkg::SUM_W) + 1;

    logic signed [EW-1:0]              prev_reg;
    logic signed [pidsc_pkg::SUM_W-1:0] sum_reg;
    logic signed [DW-1:0]              diff_reg;
    logic                              valid_reg;

    logic signed [EW-1:0]              err_next;
    logic signed [DW-1:0]              diff_next;
    logic signed [AW-1:0]              acc;
    logic signed [AW-1:0]              lim;
    logic signed [pidsc_pkg::SUM_W-1:0] sum_next;
    logic                              take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        err_next  = EW'(setpoint) - EW'(sample);
        diff_next = DW'(err_next) - DW'(prev_reg);
        acc       = AW'(sum_reg) + AW'(err_next);
        lim       = $signed(AW'(integral_limit));
        if (acc > lim)
        begin
            sum_next = pidsc_pkg::SUM_W'(lim);
        end
        else if (acc < -lim)
        begin
            sum_next = pidsc_pkg::SUM_W'(-lim);
        end
        else
        begin
            sum_next = pidsc_pkg::SUM_W'(acc);
        end
    end

    // state doubles as the stage register: it moves only when a new word enters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                sum_reg  <= sum_next;
                prev_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff_reg <= diff_next;
        end
    end

    assign out_valid = valid_reg;
    assign err       = prev_reg;
    assign error_sum = sum_reg;
    assign diff      = diff_reg;

endmodule

/* rtl/pidsc_product_stage.sv */
// Product stage: the three gain multiplies, each registered.
// Uses pidsc_pkg for gain and integrator widths.
module pidsc_product_stage #(
    parameter int EW = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [EW-1:0]                err,
    input  logic signed [pidsc_pkg::SUM_W-1:0]  error_sum,
    input  logic signed [EW:0]                  diff,
    input  logic signed [pidsc_pkg::GAIN_W-1:0] kp,
    input  logic signed [pidsc_pkg::GAIN_W-1:0] ki,
    input  logic signed [pidsc_pkg::GAIN_W-1:0] kd,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pidsc_pkg::GAIN_W+EW-1:0]              p_term,
    output logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::SUM_W-1:0] i_term,
    output logic signed [pidsc_pkg::GAIN_W+EW:0]                d_term
);

    localparam int PW = pidsc_pkg::GAIN_W + EW;
    localparam int IW = pidsc_pkg::GAIN_W + pidsc_pkg::SUM_W;
    localparam int DPW = pidsc_pkg::GAIN_W + EW + 1;

    logic signed [PW-1:0]  p_reg;
    logic signed [IW-1:0]  i_reg;
    logic signed [DPW-1:0] d_reg;
    logic                  valid_reg;
    logic                  take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_reg <= PW'(kp) * PW'(err);
            i_reg <= IW'(ki) * IW'(error_sum);
            d_reg <= DPW'(kd) * DPW'(diff);
        end
    end

    assign out_valid = valid_reg;
    assign p_term    = p_reg;
    assign i_term    = i_reg;
    assign d_term    = d_reg;

endmodule

/* rtl/pidsc_output_stage.sv */
// Output stage: sums the terms, drops the gain fraction rounding toward zero,
// saturates to 32 bits and holds the result word. Uses pidsc_pkg.
module pidsc_output_stage #(
    parameter int EW             = 17,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pidsc_pkg::GAIN_W+EW-1:0]              p_term,
    input  logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::SUM_W-1:0] i_term,
    input  logic signed [pidsc_pkg::GAIN_W+EW:0]                d_term,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pidsc_pkg::DRIVE_W-1:0]       drive_value
);

    localparam int DPW = pidsc_pkg::GAIN_W + EW + 1;
    localparam int IW  = pidsc_pkg::GAIN_W + pidsc_pkg::SUM_W;
    // widest term plus two bits of growth for the three-way sum
    localparam int TW  = ((DPW > IW) ? DPW : IW) + 2;
    localparam logic signed [TW-1:0] BIAS = (TW'(1) << GAIN_FRAC_BITS) - TW'(1);
    localparam logic signed [TW-1:0] MAXV =
        TW'($signed({1'b0, {(pidsc_pkg::DRIVE_W-1){1'b1}}}));
    localparam logic signed [TW-1:0] MINV =
        TW'($signed({1'b1, {(pidsc_pkg::DRIVE_W-1){1'b0}}}));

    logic signed [TW-1:0]               total;
    logic signed [TW-1:0]               biased;
    logic signed [TW-1:0]               shifted;
    logic [pidsc_pkg::DRIVE_W-1:0]      drive_next;
    logic [pidsc_pkg::DRIVE_W-1:0]      drive_reg;
    logic                               valid_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        total   = TW'(p_term) + TW'(i_term) + TW'(d_term);
        // add fraction-minus-one on negatives so the shift truncates toward zero
        biased  = total + (total[TW-1] ? BIAS : '0);
        shifted = biased >>> GAIN_FRAC_BITS;
        if (shifted > MAXV)
        begin
            drive_next = MAXV[pidsc_pkg::DRIVE_W-1:0];
        end
        else if (shifted < MINV)
        begin
            drive_next = MINV[pidsc_pkg::DRIVE_W-1:0];
        end
        else
        begin
            drive_next = shifted[pidsc_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid   = valid_reg;
    assign drive_value = drive_reg;

endmodule

/* rtl/pidsc_checker.sv */
// Port-level checker for pid_speed_controller_clamped, bound to the top level.
// Tracks words in flight and zero gains from the ports alone; uses pidsc_pkg.
module pidsc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pidsc_pkg::DRIVE_W-1:0]     m_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [pidsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [pidsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] DEPTH = 3'd4;

    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [2:0] gain_zero_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb
    begin
        count_next = count_reg;
        if (s_acc && !m_acc)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (m_acc && !s_acc)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            gain_zero_reg <= 3'b111;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pidsc_pkg::REG_KP: gain_zero_reg[0] <= (cfg_data[15:0] == '0);
                    pidsc_pkg::REG_KI: gain_zero_reg[1] <= (cfg_data[15:0] == '0);
                    pidsc_pkg::REG_KD: gain_zero_reg[2] <= (cfg_data[15:0] == '0);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> count_reg != 3'd0)
        else $error("result word shown with no word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !(count_reg == DEPTH && s_acc && !m_acc))
        else $error("more words in flight than pipeline stages");

    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && gain_zero_reg == 3'b111 |-> m_tdata == '0)
        else $error("nonzero drive with all gains zero");

endmodule

bind pid_speed_controller_clamped pidsc_checker u_pidsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
